### rtl/stereo_state_variable_lowpass_top_defines.svh
// Assertion macros for the stereo low-pass RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef STEREO_STATE_VARIABLE_LOWPASS_TOP_DEFINES_SVH
`define STEREO_STATE_VARIABLE_LOWPASS_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SSVL_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SSVL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ssvl_pkg.sv
// Shared types and constants for the stereo state-variable low-pass block.
// No dependencies; used by the config, controller, datapath and top files.
package ssvl_pkg;

  localparam int SAMPLE_W = 16;
  localparam int Q_FRAC   = 15;

  localparam logic [14:0] Q_BASE  = 15'd22938;
  localparam logic [14:0] Q_SLOPE = 15'd19661;
  localparam logic [14:0] Q_MIN   = 15'd3277;

  localparam int          FREQ_RESET = 37178;
  localparam logic [15:0] RES_RESET  = 16'd9830;

  // register index (paddr[3:2])
  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_FREQ   = 2'd1;
  localparam logic [1:0] REG_RES    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_FB,
    ST_LOW,
    ST_HIGH,
    ST_MUL_FH,
    ST_BAND,
    ST_DONE
  } ctrl_state_t;

  typedef enum logic [2:0] {
    DP_IDLE,
    DP_LOAD,
    DP_BYPASS,
    DP_MUL_FB,
    DP_LOW,
    DP_HIGH,
    DP_MUL_FH,
    DP_BAND
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   ch;
    logic   out_load;
  } dp_cmd_t;

  // damping q = 22938 - (19661*res >> 15), floored at 3277
  function automatic logic [14:0] q_from_res(input logic [15:0] res);
    logic [30:0]        prod;
    logic signed [17:0] diff;
    prod = 31'(Q_SLOPE) * 31'(res);
    diff = $signed({3'b000, Q_BASE}) - $signed({2'b00, prod[30:15]});
    if (diff < $signed({3'b000, Q_MIN})) begin
      return Q_MIN;
    end
    return diff[14:0];
  endfunction

endpackage

### rtl/ssvl_cfg.sv
// APB-style register file: enable, frequency coefficient, resonance.
// Depends on ssvl_pkg for register indexes and reset values.
module ssvl_cfg #(
  parameter int COEFFICIENT_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic                         enable_o,
  output logic [COEFFICIENT_WIDTH-1:0] coef_o,
  output logic [15:0]                  res_o
);

  logic                         enable_r;
  logic [COEFFICIENT_WIDTH-1:0] coef_r;
  logic [15:0]                  res_r;
  logic                         wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      coef_r   <= COEFFICIENT_WIDTH'(ssvl_pkg::FREQ_RESET);
      res_r    <= ssvl_pkg::RES_RESET;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        ssvl_pkg::REG_ENABLE: enable_r <= pwdata[0];
        ssvl_pkg::REG_FREQ:   coef_r   <= pwdata[COEFFICIENT_WIDTH-1:0];
        ssvl_pkg::REG_RES:    res_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ssvl_pkg::REG_ENABLE: prdata = {31'b0, enable_r};
      ssvl_pkg::REG_FREQ:   prdata = 32'(coef_r);
      ssvl_pkg::REG_RES:    prdata = {16'b0, res_r};
      default:              prdata = '0;
    endcase
  end

  assign enable_o = enable_r;
  assign coef_o   = coef_r;
  assign res_o    = res_r;

endmodule

### rtl/ssvl_ctrl.sv
// Sequencer for the two-channel filter step and the stream handshakes.
// Depends on ssvl_pkg and the assertion macro header.
`include "stereo_state_variable_lowpass_top_defines.svh"

module ssvl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  logic              enable_i,
  output ssvl_pkg::dp_cmd_t cmd_o
);

  ssvl_pkg::ctrl_state_t state_r, state_nxt;
  logic                  ch_r, ch_nxt;
  logic                  out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssvl_pkg::ST_IDLE;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    ch_nxt         = ch_r;
    out_valid_nxt  = out_valid_r;
    cmd_o.op       = ssvl_pkg::DP_IDLE;
    cmd_o.ch       = ch_r;
    cmd_o.out_load = 1'b0;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ssvl_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (enable_i) begin
            cmd_o.op  = ssvl_pkg::DP_LOAD;
            ch_nxt    = 1'b0;
            state_nxt = ssvl_pkg::ST_MUL_FB;
          end else begin
            cmd_o.op  = ssvl_pkg::DP_BYPASS;
            state_nxt = ssvl_pkg::ST_DONE;
          end
        end
      end
      ssvl_pkg::ST_MUL_FB: begin
        cmd_o.op  = ssvl_pkg::DP_MUL_FB;
        state_nxt = ssvl_pkg::ST_LOW;
      end
      ssvl_pkg::ST_LOW: begin
        cmd_o.op  = ssvl_pkg::DP_LOW;
        state_nxt = ssvl_pkg::ST_HIGH;
      end
      ssvl_pkg::ST_HIGH: begin
        cmd_o.op  = ssvl_pkg::DP_HIGH;
        state_nxt = ssvl_pkg::ST_MUL_FH;
      end
      ssvl_pkg::ST_MUL_FH: begin
        cmd_o.op  = ssvl_pkg::DP_MUL_FH;
        state_nxt = ssvl_pkg::ST_BAND;
      end
      ssvl_pkg::ST_BAND: begin
        cmd_o.op = ssvl_pkg::DP_BAND;
        if (ch_r) begin
          state_nxt = ssvl_pkg::ST_DONE;
        end else begin
          ch_nxt    = 1'b1;
          state_nxt = ssvl_pkg::ST_MUL_FB;
        end
      end
      ssvl_pkg::ST_DONE: begin
        // output register free or emptying this cycle
        if (!out_valid_r || out_tready) begin
          cmd_o.out_load = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = ssvl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ssvl_pkg::ST_IDLE;
    endcase
  end

  assign in_tready  = (state_r == ssvl_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;

  `SSVL_ASSERT_NEXT(a_start_left, in_tvalid && in_tready && enable_i, (state_r == ssvl_pkg::ST_MUL_FB) && !ch_r, "filtered frame must start on the left channel")
  `SSVL_ASSERT_NEXT(a_right_ends, (state_r == ssvl_pkg::ST_BAND) && ch_r, state_r == ssvl_pkg::ST_DONE, "right band update must finish the frame")
  `SSVL_ASSERT_IMPL(a_out_from_done, out_valid_r && !$past(out_valid_r), $past(state_r) == ssvl_pkg::ST_DONE, "result beat raised outside the done state")

endmodule

### rtl/ssvl_dp.sv
// Datapath: filter state, shared multiplier, saturation and output scaling.
// Depends on ssvl_pkg for the command struct and the damping function.
module ssvl_dp #(
  parameter int STATE_WIDTH       = 32,
  parameter int COEFFICIENT_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ssvl_pkg::dp_cmd_t            cmd_i,
  input  logic [15:0]                  left_i,
  input  logic [15:0]                  right_i,
  input  logic                         last_i,
  input  logic [COEFFICIENT_WIDTH-1:0] coef_i,
  input  logic [15:0]                  res_i,
  output logic [15:0]                  left_o,
  output logic [15:0]                  right_o,
  output logic                         last_o
);

  localparam int SW   = STATE_WIDTH;
  localparam int FRAC = SW - 8;
  localparam int XS   = FRAC - 15;
  localparam int CF   = COEFFICIENT_WIDTH - 1;
  localparam int MBW  = ((COEFFICIENT_WIDTH > 16) ? COEFFICIENT_WIDTH : 16) + 1;
  localparam int PW   = SW + MBW;
  localparam int EW   = SW + 2;
  localparam int YW   = SW + 17;

  localparam logic signed [SW-1:0] SMAX  = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN  = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [YW-1:0] YBIAS = {{(YW-FRAC){1'b0}}, {FRAC{1'b1}}};
  localparam logic signed [YW-1:0] YMAX  = YW'(32767);
  localparam logic signed [YW-1:0] YMIN  = -YW'(32768);

  function automatic logic signed [SW-1:0] sat_fn(input logic signed [EW-1:0] v);
    if (v > EW'(SMAX)) begin
      return SMAX;
    end
    if (v < EW'(SMIN)) begin
      return SMIN;
    end
    return v[SW-1:0];
  endfunction

  logic signed [SW-1:0] low_r  [2];
  logic signed [SW-1:0] band_r [2];
  logic        [15:0]   xl_r, xr_r;
  logic        [14:0]   q_r;
  logic signed [PW-1:0] prod_r;
  logic signed [SW-1:0] hp_r;
  logic signed [SW+15:0] scl_r;
  logic        [15:0]   yl_r, yr_r;
  logic                 last_r;
  logic        [15:0]   out_l_r, out_r_r;
  logic                 out_last_r;

  logic signed [SW-1:0]  low_cur, band_cur, a_sel;
  logic signed [MBW-1:0] b_sel;
  logic signed [PW-1:0]  prod_w, fsh_full, qsh_full;
  logic signed [EW-1:0]  fsh_e, qsh_e, low_e, band_e, x_e;
  logic signed [SW-8:0]  x_sh;
  logic        [15:0]    x_sel;
  logic signed [SW-1:0]  lp_w, hp_w, bp_w;
  logic signed [SW+14:0] lp15;
  logic signed [SW+15:0] scl_w;
  logic signed [YW-1:0]  yt, ysh;
  logic        [15:0]    y_w;

  assign low_cur  = low_r[cmd_i.ch];
  assign band_cur = band_r[cmd_i.ch];

  // shared multiplier: f*band, q*band, f*high
  assign a_sel  = (cmd_i.op == ssvl_pkg::DP_MUL_FH) ? hp_r : band_cur;
  assign b_sel  = (cmd_i.op == ssvl_pkg::DP_LOW) ? MBW'(q_r) : MBW'(coef_i);
  assign prod_w = a_sel * b_sel;

  assign fsh_full = prod_r >>> CF;
  assign qsh_full = prod_r >>> ssvl_pkg::Q_FRAC;
  assign fsh_e    = fsh_full[EW-1:0];
  assign qsh_e    = qsh_full[EW-1:0];
  assign low_e    = EW'(low_cur);
  assign band_e   = EW'(band_cur);

  assign x_sel = cmd_i.ch ? xr_r : xl_r;
  assign x_sh  = {x_sel, {XS{1'b0}}};
  assign x_e   = EW'(x_sh);

  assign lp_w = sat_fn(low_e + fsh_e);
  assign hp_w = sat_fn(x_e - low_e - qsh_e);
  assign bp_w = sat_fn(band_e + fsh_e);

  // low * 32767 as (low << 15) - low
  assign lp15  = {low_cur, 15'b0};
  assign scl_w = (SW+16)'(lp15) - (SW+16)'(low_cur);

  // truncate toward zero: bias negatives before the shift
  assign yt  = YW'(scl_r) + (scl_r[SW+15] ? YBIAS : '0);
  assign ysh = yt >>> FRAC;
  always_comb begin
    if (ysh > YMAX) begin
      y_w = 16'h7FFF;
    end else if (ysh < YMIN) begin
      y_w = 16'h8000;
    end else begin
      y_w = ysh[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r[0]  <= '0;
      low_r[1]  <= '0;
      band_r[0] <= '0;
      band_r[1] <= '0;
    end else begin
      if (cmd_i.op == ssvl_pkg::DP_LOW) begin
        low_r[cmd_i.ch] <= lp_w;
      end
      if (cmd_i.op == ssvl_pkg::DP_BAND) begin
        band_r[cmd_i.ch] <= bp_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd_i.op)
      ssvl_pkg::DP_LOAD: begin
        xl_r   <= left_i;
        xr_r   <= right_i;
        last_r <= last_i;
        q_r    <= ssvl_pkg::q_from_res(res_i);
      end
      ssvl_pkg::DP_BYPASS: begin
        yl_r   <= left_i;
        yr_r   <= right_i;
        last_r <= last_i;
      end
      ssvl_pkg::DP_MUL_FB: prod_r <= prod_w;
      ssvl_pkg::DP_LOW:    prod_r <= prod_w;
      ssvl_pkg::DP_HIGH: begin
        hp_r  <= hp_w;
        scl_r <= scl_w;
      end
      ssvl_pkg::DP_MUL_FH: begin
        prod_r <= prod_w;
        if (cmd_i.ch) begin
          yr_r <= y_w;
        end else begin
          yl_r <= y_w;
        end
      end
      ssvl_pkg::DP_BAND: ;
      ssvl_pkg::DP_IDLE: ;
      default: ;
    endcase
    if (cmd_i.out_load) begin
      out_l_r    <= yl_r;
      out_r_r    <= yr_r;
      out_last_r <= last_r;
    end
  end

  assign left_o  = out_l_r;
  assign right_o = out_r_r;
  assign last_o  = out_last_r;

endmodule

### rtl/stereo_state_variable_lowpass_top.sv
// Stereo Chamberlin state-variable low-pass filter, top level.
// Input stream: in_tdata = {right_sample, left_sample}, in_tlast = block_end_in.
// Output stream: out_tdata = {right_filtered, left_filtered}, out_tlast = block_end_out.
// Config (APB-style): 0x0 filter_enable, 0x4 frequency_coefficient,
//   0x8 resonance_amount; write only while no frame is in flight.
// A frame is taken when in_tready is high, which is whenever the sequencer
// is idle. A filtered frame is worked through two channels of five steps
// each through one shared multiplier (f*band, low update with q*band,
// high, f*high, band update), then loaded into the output register, after
// which the sequencer is idle again. Bypassed frames (filter_enable = 0)
// go straight to the output load and leave the state untouched. One frame
// is in work at a time; the output register holds a finished beat so a
// new frame can be accepted while it waits.
// If out_tready stays low the sequencer holds its next result and stalls.
// Reset (rst_n low, synchronous) clears the filter state and the output
// valid, and restores the register defaults.
module stereo_state_variable_lowpass_top #(
  parameter int STATE_WIDTH       = 32,
  parameter int COEFFICIENT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] left_sample, [31:16] right_sample
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] left_filtered, [31:16] right_filtered
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic                         enable;
  logic [COEFFICIENT_WIDTH-1:0] coef;
  logic [15:0]                  res;
  ssvl_pkg::dp_cmd_t            cmd;
  logic [15:0]                  left_out, right_out;

  ssvl_cfg #(
    .COEFFICIENT_WIDTH(COEFFICIENT_WIDTH)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready),
    .enable_o (enable),
    .coef_o   (coef),
    .res_o    (res)
  );

  ssvl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .enable_i   (enable),
    .cmd_o      (cmd)
  );

  ssvl_dp #(
    .STATE_WIDTH       (STATE_WIDTH),
    .COEFFICIENT_WIDTH (COEFFICIENT_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd_i   (cmd),
    .left_i  (in_tdata[15:0]),
    .right_i (in_tdata[31:16]),
    .last_i  (in_tlast),
    .coef_i  (coef),
    .res_i   (res),
    .left_o  (left_out),
    .right_o (right_out),
    .last_o  (out_tlast)
  );

  assign out_tdata = {right_out, left_out};

endmodule

### tb/stereo_state_variable_lowpass_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the stereo state-variable low-pass top level.
// Uses ssvl_pkg for register indexes; predicts every output beat in-house.

module stereo_state_variable_lowpass_top_test;

  localparam int         FRAC_W       = 24;  // state is Q8.24
  localparam logic [1:0] REG_SPARE    = 2'd3;
  localparam int         HOLD_AT      = 700;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         PHASE_FRAMES = 166;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               last;
  } frame_t;

  typedef enum {ROW_FRAME, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  idx;
    logic [31:0] value;
    frame_t      stim;
    bit          typed;
    frame_t      result;
  } step_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata    = '0;  // [15:0] left_sample, [31:16] right_sample
  logic        in_tlast    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;         // [15:0] left_filtered, [31:16] right_filtered
  logic        out_tlast;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // filter model: registers and per-channel state
  bit          model_enable = 1'b0;
  logic [15:0] model_freq   = 16'd37178;
  logic [15:0] model_res    = 16'd9830;
  longint      low_state [2] = '{0, 0};
  longint      band_state[2] = '{0, 0};

  frame_t pending_frames[$];
  frame_t head;
  step_t  directed_steps[$];
  logic signed [15:0] corner_vals[4] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};

  bit steady      = 1'b0;
  bit hold_done   = 1'b0;
  int hold_left   = 0;
  int results_seen = 0;
  int errors      = 0;
  int frames_filtered = 0;
  int frames_bypassed = 0;
  int reg_writes  = 0;

  stereo_state_variable_lowpass_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic longint clamp_state(input longint v);
    longint hi;
    hi = (longint'(1) <<< 31) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // damping from resonance, floored at 0.1
  function automatic longint damping();
    longint q;
    q = 22938 - ((longint'(19661) * longint'(model_res)) >>> 15);
    if (q < 3277) q = 3277;
    return q;
  endfunction

  function automatic logic [15:0] filter_channel(input int ch, input logic signed [15:0] s,
                                                 input longint f, input longint q);
    longint x, lp, hp, bp, y;
    x  = longint'(s) * 512;
    lp = clamp_state(low_state[ch] + ((f * band_state[ch]) >>> 15));
    hp = clamp_state(x - lp - ((q * band_state[ch]) >>> 15));
    bp = clamp_state(band_state[ch] + ((f * hp) >>> 15));
    low_state[ch]  = lp;
    band_state[ch] = bp;
    // signed divide truncates toward zero
    y = (lp * 32767) / (longint'(1) <<< FRAC_W);
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    return y[15:0];
  endfunction

  function automatic frame_t filter_frame(input frame_t in);
    frame_t res;
    longint q;
    res = in;
    if (model_enable) begin
      q = damping();
      res.left  = filter_channel(0, in.left, longint'(model_freq), q);
      res.right = filter_channel(1, in.right, longint'(model_freq), q);
    end
    return res;
  endfunction

  function automatic step_t frame_row(input int l, input int r, input int last,
                                      input int typed, input int el, input int er);
    step_t s;
    s.kind = ROW_FRAME;
    s.idx = '0;
    s.value = '0;
    s.stim.left = 16'(l);
    s.stim.right = 16'(r);
    s.stim.last = 1'(last);
    s.typed = 1'(typed);
    s.result.left = 16'(el);
    s.result.right = 16'(er);
    s.result.last = 1'(last);
    return s;
  endfunction

  function automatic step_t write_row(input logic [1:0] idx, input logic [31:0] value);
    step_t s;
    s = frame_row(0, 0, 0, 0, 0, 0);
    s.kind = ROW_CFG;
    s.idx = idx;
    s.value = value;
    return s;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      ssvl_pkg::REG_ENABLE: model_enable = value[0];
      ssvl_pkg::REG_FREQ:   model_freq = value[15:0];
      ssvl_pkg::REG_RES:    model_res = value[15:0];
      default: ;  // spare address, write dropped
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  // stop offering and let every frame in flight come out
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic send_frame(input frame_t f, input bit typed, input frame_t want);
    int gap;
    frame_t predicted;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(99) < 32 && gap < 12) gap++;
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {f.right, f.left};
    in_tlast  <= f.last;
    do @(posedge clk); while (!in_tready);
    if (model_enable) frames_filtered++;
    else frames_bypassed++;
    predicted = filter_frame(f);
    if (typed) pending_frames.push_back(want);
    else pending_frames.push_back(predicted);
  endtask

  // result side: check each beat, then pick next tready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_frames.size() == 0) begin
        $error("result beat with nothing expected: tdata %h", out_tdata);
        errors++;
      end else begin
        head = pending_frames.pop_front();
        if (out_tdata[15:0] !== head.left) begin
          $error("left_filtered: expected %0d, got %0d", head.left, $signed(out_tdata[15:0]));
          errors++;
        end
        if (out_tdata[31:16] !== head.right) begin
          $error("right_filtered: expected %0d, got %0d", head.right,
                 $signed(out_tdata[31:16]));
          errors++;
        end
        if (out_tlast !== head.last) begin
          $error("block_end_out: expected %0b, got %0b", head.last, out_tlast);
          errors++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      // long back-pressure so the input side stalls
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(99) >= 32);
    end
  end

  initial begin
    int p, k, sel, tri_level, tri_step;
    logic [31:0] en_val, freq_val, res_val;
    frame_t stim;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // disabled after reset: samples come straight back
    directed_steps.push_back(frame_row(0, 0, 0, 1, 0, 0));
    directed_steps.push_back(frame_row(32767, -32768, 1, 1, 32767, -32768));
    directed_steps.push_back(frame_row(-32768, 32767, 0, 1, -32768, 32767));
    directed_steps.push_back(frame_row(-1, 1, 1, 1, -1, 1));
    directed_steps.push_back(frame_row(21845, -21846, 0, 1, 21845, -21846));
    // zero cutoff: low-pass state never leaves zero
    directed_steps.push_back(write_row(ssvl_pkg::REG_FREQ, 32'd0));
    directed_steps.push_back(write_row(ssvl_pkg::REG_ENABLE, 32'd1));
    directed_steps.push_back(frame_row(32767, -32768, 1, 1, 0, 0));
    directed_steps.push_back(frame_row(-32768, 32767, 0, 1, 0, 0));
    directed_steps.push_back(frame_row(12345, -12345, 1, 1, 0, 0));
    // top of range, no resonance: full-scale steps
    directed_steps.push_back(write_row(ssvl_pkg::REG_FREQ, 32'd44861));
    directed_steps.push_back(write_row(ssvl_pkg::REG_RES, 32'd0));
    repeat (4) directed_steps.push_back(frame_row(32767, 32767, 0, 0, 0, 0));
    repeat (3) directed_steps.push_back(frame_row(-32768, -32768, 1, 0, 0, 0));
    // coefficient past its range, resonance one: drive into saturation
    directed_steps.push_back(write_row(ssvl_pkg::REG_FREQ, 32'd65535));
    directed_steps.push_back(write_row(ssvl_pkg::REG_RES, 32'd32768));
    directed_steps.push_back(frame_row(32767, -32768, 0, 0, 0, 0));
    directed_steps.push_back(frame_row(-32768, 32767, 1, 0, 0, 0));
    directed_steps.push_back(frame_row(32767, -32768, 0, 0, 0, 0));
    directed_steps.push_back(frame_row(-32768, 32767, 0, 0, 0, 0));
    // resonance above one clamps the damping
    directed_steps.push_back(write_row(ssvl_pkg::REG_RES, 32'd65535));
    directed_steps.push_back(frame_row(32767, -32768, 1, 0, 0, 0));
    directed_steps.push_back(frame_row(-32768, 32767, 0, 0, 0, 0));
    directed_steps.push_back(write_row(REG_SPARE, 32'd0));
    directed_steps.push_back(frame_row(100, -100, 0, 0, 0, 0));
    // disable again: bypass with state held
    directed_steps.push_back(write_row(ssvl_pkg::REG_ENABLE, 32'd0));
    directed_steps.push_back(frame_row(1234, -4321, 1, 1, 1234, -4321));

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(directed_steps[i].idx, directed_steps[i].value);
      end else begin
        send_frame(directed_steps[i].stim, directed_steps[i].typed, directed_steps[i].result);
      end
    end

    for (p = 0; p < 8; p++) begin
      wait_idle();
      en_val = 32'd1;
      case (p)
        0: begin freq_val = 32'd37178; res_val = 32'd9830; end
        1: begin freq_val = $urandom_range(44861); res_val = $urandom_range(32768); end
        2: begin freq_val = 32'd44861; res_val = 32'd32768; end
        3: begin freq_val = 32'd0; res_val = 32'd0; end
        4: begin freq_val = 32'd65535; res_val = 32'd65535; end
        5: begin
          en_val = 32'd0;
          freq_val = $urandom_range(44861);
          res_val = $urandom_range(32768);
        end
        6: begin freq_val = 32'd1200; res_val = 32'd16384; end
        default: begin freq_val = $urandom_range(65535); res_val = $urandom_range(65535); end
      endcase
      write_reg(ssvl_pkg::REG_FREQ, freq_val);
      write_reg(ssvl_pkg::REG_RES, res_val);
      write_reg(ssvl_pkg::REG_ENABLE, en_val);
      tri_level = 0;
      tri_step = $urandom_range(3000, 200);
      steady = (p == 2);
      for (k = 0; k < PHASE_FRAMES; k++) begin
        if (k == 150) steady = 1'b0;
        sel = $urandom_range(99);
        if (sel < 40) begin
          stim.left = 16'($urandom);
          stim.right = 16'($urandom);
        end else if (sel < 55) begin
          stim.left = corner_vals[$urandom_range(3)];
          stim.right = corner_vals[$urandom_range(3)];
        end else begin
          // triangle wave, mirrored on the right channel
          tri_level += tri_step;
          if (tri_level > 32000 || tri_level < -32000) begin
            tri_step = -tri_step;
            tri_level += 2 * tri_step;
          end
          stim.left = 16'(tri_level);
          stim.right = 16'(-tri_level);
        end
        stim.last = ($urandom_range(7) == 0);
        send_frame(stim, 1'b0, stim);
      end
    end
    steady = 1'b0;
    wait_idle();

    $display("Ran %0d filtered and %0d bypassed frames across %0d register writes,",
             frames_filtered, frames_bypassed, reg_writes);
    $display("including saturation, out-of-range coefficients and a long output stall.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
